FILE: rtl/pga_pkg.sv
// Package with the payload types, register map and constants of the PWM-gated ADC accumulator.
package pga_pkg;

    localparam int LED_SLOTS   = 3;
    localparam int NUM_LEDS    = 3;
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = 5;

    localparam logic [1:0] ACT_COMPARE     = 2'd0;
    localparam logic [1:0] ACT_CONVERT_END = 2'd1;
    localparam logic [1:0] ACT_READ        = 2'd2;

    localparam logic [2:0] REG_ACTIVE_LED = 3'd0;
    localparam logic [2:0] REG_LED1_VOLT  = 3'd1;
    localparam logic [2:0] REG_LED1_CURR  = 3'd2;
    localparam logic [2:0] REG_LED2_VOLT  = 3'd3;
    localparam logic [2:0] REG_LED2_CURR  = 3'd4;
    localparam logic [2:0] REG_LED3_VOLT  = 3'd5;
    localparam logic [2:0] REG_LED3_CURR  = 3'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] led;
        logic       pwm_low;
        logic [9:0] sample;
        logic [2:0] read_channel;
    } t_in;

    typedef struct packed {
        logic        start_conversion;
        logic [2:0]  convert_channel;
        logic        sample_accepted;
        logic [15:0] sum;
        logic [6:0]  count;
    } t_out;

    typedef struct packed {
        logic [1:0]                          active_led;
        logic [LED_SLOTS-1:0][1:0][2:0]      led_chan;
    } t_cfg;

endpackage

FILE: rtl/pga_regs.sv
// Configuration register file behind the APB-style port.
module pga_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [pga_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output pga_pkg::t_cfg             o_cfg
);
    import pga_pkg::*;

    logic [1:0]                     r_active;
    logic [LED_SLOTS-1:0][1:0][2:0] r_chan;
    logic                           wr_en;
    logic [2:0]                     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 2'd1;
            r_chan[0][0] <= 3'd0;
            r_chan[0][1] <= 3'd3;
            r_chan[1][0] <= 3'd1;
            r_chan[1][1] <= 3'd6;
            r_chan[2][0] <= 3'd2;
            r_chan[2][1] <= 3'd7;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ACTIVE_LED: r_active     <= pwdata[1:0];
                REG_LED1_VOLT:  r_chan[0][0] <= pwdata[2:0];
                REG_LED1_CURR:  r_chan[0][1] <= pwdata[2:0];
                REG_LED2_VOLT:  r_chan[1][0] <= pwdata[2:0];
                REG_LED2_CURR:  r_chan[1][1] <= pwdata[2:0];
                REG_LED3_VOLT:  r_chan[2][0] <= pwdata[2:0];
                REG_LED3_CURR:  r_chan[2][1] <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_LED: prdata = 32'(r_active);
            REG_LED1_VOLT:  prdata = 32'(r_chan[0][0]);
            REG_LED1_CURR:  prdata = 32'(r_chan[0][1]);
            REG_LED2_VOLT:  prdata = 32'(r_chan[1][0]);
            REG_LED2_CURR:  prdata = 32'(r_chan[1][1]);
            REG_LED3_VOLT:  prdata = 32'(r_chan[2][0]);
            REG_LED3_CURR:  prdata = 32'(r_chan[2][1]);
            default:        prdata = 32'd0;
        endcase
    end

    assign o_cfg.active_led = r_active;
    assign o_cfg.led_chan   = r_chan;

endmodule

FILE: rtl/pga_core.sv
// Channel accumulators, LED toggles, pending request and the result register.
module pga_core #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pga_pkg::t_in  i_item,
    input  pga_pkg::t_cfg i_cfg,
    output logic          o_valid,
    output pga_pkg::t_out o_result
);
    import pga_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic [LED_SLOTS-1:0] r_toggle;
    logic [LED_SLOTS-1:0] n_toggle;
    logic [15:0]          r_sum [NUM_CHANNELS];
    logic [6:0]           r_cnt [NUM_CHANNELS];
    logic                 r_pend_valid;
    logic                 n_pend_valid;
    logic [2:0]           r_pend_ch;
    logic [2:0]           n_pend_ch;
    logic                 r_out_valid;
    t_out                 r_out;
    t_out                 n_out;

    logic                 served;
    logic [1:0]           li;
    logic                 sel;
    logic [2:0]           pick;
    logic [2:0]           raw_ch;
    logic                 in_range;
    logic [CH_W-1:0]      addr;
    logic [15:0]          rd_sum;
    logic [6:0]           rd_cnt;
    logic [16:0]          sum_add;
    logic                 wr_en;
    logic [15:0]          wr_sum;
    logic [6:0]           wr_cnt;

    always_comb begin
        served = (i_item.action == ACT_COMPARE) && (i_item.led != 2'd0)
                 && (32'(i_item.led) <= NUM_LEDS) && (i_item.led == i_cfg.active_led)
                 && i_item.pwm_low;
        li     = served ? (i_item.led - 2'd1) : 2'd0;
        sel    = r_toggle[li];
        pick   = i_cfg.led_chan[li][sel];
        case (i_item.action)
            ACT_COMPARE:     raw_ch = pick;
            ACT_CONVERT_END: raw_ch = r_pend_ch;
            ACT_READ:        raw_ch = i_item.read_channel;
            default:         raw_ch = 3'd0;
        endcase
        in_range = 32'(raw_ch) < NUM_CHANNELS;
        addr     = CH_W'(raw_ch);
        rd_sum   = r_sum[addr];
        rd_cnt   = r_cnt[addr];
        sum_add  = 17'(rd_sum) + 17'(i_item.sample);

        n_toggle     = r_toggle;
        n_pend_valid = r_pend_valid;
        n_pend_ch    = r_pend_ch;
        wr_en        = 1'b0;
        wr_sum       = 16'd0;
        wr_cnt       = 7'd0;
        n_out        = '0;

        if (i_valid) begin
            case (i_item.action)
                ACT_COMPARE: begin
                    if (served) begin
                        n_toggle[li]          = ~sel;
                        n_out.convert_channel = pick;
                        if (in_range && (32'(rd_cnt) < MAX_SAMPLES)) begin
                            n_out.start_conversion = 1'b1;
                            n_pend_valid           = 1'b1;
                            n_pend_ch              = pick;
                        end
                    end
                end
                ACT_CONVERT_END: begin
                    if (r_pend_valid && i_item.pwm_low && in_range) begin
                        wr_en                 = 1'b1;
                        wr_sum                = sum_add[16] ? 16'hFFFF : sum_add[15:0];
                        wr_cnt                = (rd_cnt == 7'h7F) ? rd_cnt : rd_cnt + 7'd1;
                        n_out.sample_accepted = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                end
                ACT_READ: begin
                    if (in_range) begin
                        wr_en       = 1'b1;
                        n_out.sum   = rd_sum;
                        n_out.count = rd_cnt;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle     <= '0;
            r_pend_valid <= 1'b0;
            r_pend_ch    <= 3'd0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i] <= 16'd0;
                r_cnt[i] <= 7'd0;
            end
        end else begin
            r_toggle     <= n_toggle;
            r_pend_valid <= n_pend_valid;
            r_pend_ch    <= n_pend_ch;
            r_out_valid  <= i_valid;
            if (wr_en) begin
                r_sum[addr] <= wr_sum;
                r_cnt[addr] <= wr_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/pwm_gated_adc_accumulator.sv
// Top level of the PWM-gated ADC accumulator: input register, register file and core.
// An accepted item passes the input register and then the core's result register, and the
// result strobe is registered alongside the result.
// Throughput: one item per cycle; busy stays low, as the input register feeds a
// read-modify-write of the channel accumulators.
// The receiver cannot stall, so every result is shown for exactly one cycle.
// Synchronous active-low reset clears the accumulators, toggles, pending request and
// pipeline valid bits, and loads the register reset values.
module pwm_gated_adc_accumulator #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  pga_pkg::t_in               i_item,
    output logic                       o_valid,
    output pga_pkg::t_out              o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pga_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import pga_pkg::*;

    logic r_in_valid;
    t_in  r_in;
    t_cfg cfg;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    pga_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pga_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

FILE: rtl/pga_checker.sv
// Port-level checker for the PWM-gated ADC accumulator and its bind statement.
module pga_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input pga_pkg::t_out o_result
);
    import pga_pkg::*;

    a_strobe_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rst_n, 2)) |-> (o_valid == $past(start && !busy, 2)))
        else $error("result strobe does not match an accepted transfer two cycles earlier");

    a_one_kind_of_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result.start_conversion && o_result.sample_accepted))
        else $error("conversion request and accepted sample in one result");

    a_accept_has_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.sample_accepted) |->
        (o_result.sum == 16'd0 && o_result.count == 7'd0 && o_result.convert_channel == 3'd0))
        else $error("accepted sample carries read or channel data");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_result.count) <= MAX_SAMPLES))
        else $error("read count exceeds the sample limit");

endmodule

bind pwm_gated_adc_accumulator pga_checker u_pga_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

FILE: tb/pwm_gated_adc_accumulator_tb.sv
// Self-checking testbench for the PWM-gated ADC accumulator with directed and random transfers.
module pwm_gated_adc_accumulator_tb;

    import pga_pkg::*;

    localparam int NUM_CH = 8;
    localparam int IN_W = $bits(t_in);
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam t_out NO_RESULT = '0;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out result;
    } t_dir_row;

    localparam int NUM_ROWS = 22;

    // Rows marked typed carry a hand-derived expectation; the rest use the predictor.
    localparam t_dir_row DIRECTED_ROWS [NUM_ROWS] = '{
        '{'{ACT_READ, 2'd0, 1'b0, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd1, 1'b1, 10'd0, 3'd0}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'd0, 7'd0}},
        '{'{ACT_CONVERT_END, 2'd0, 1'b1, 10'd1023, 3'd0}, 1'b1,
            '{1'b0, 3'd0, 1'b1, 16'd0, 7'd0}},
        '{'{ACT_COMPARE, 2'd1, 1'b1, 10'd1023, 3'd7}, 1'b1, '{1'b1, 3'd3, 1'b0, 16'd0, 7'd0}},
        '{'{ACT_CONVERT_END, 2'd3, 1'b0, 10'd5, 3'd7}, 1'b1, NO_RESULT},
        '{'{ACT_CONVERT_END, 2'd1, 1'b1, 10'd100, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd2, 1'b1, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd0, 1'b1, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd3, 1'b1, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd1, 1'b0, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_NONE, 2'd3, 1'b1, 10'd1023, 3'd7}, 1'b1, NO_RESULT},
        '{'{ACT_READ, 2'd3, 1'b1, 10'd1023, 3'd0}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'd1023, 7'd1}},
        '{'{ACT_READ, 2'd0, 1'b0, 10'd0, 3'd0}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd1, 1'b1, 10'd0, 3'd0}, 1'b1, '{1'b1, 3'd0, 1'b0, 16'd0, 7'd0}},
        '{'{ACT_COMPARE, 2'd1, 1'b1, 10'd0, 3'd0}, 1'b1, '{1'b1, 3'd3, 1'b0, 16'd0, 7'd0}},
        '{'{ACT_CONVERT_END, 2'd0, 1'b1, 10'd0, 3'd0}, 1'b1, '{1'b0, 3'd0, 1'b1, 16'd0, 7'd0}},
        '{'{ACT_READ, 2'd0, 1'b0, 10'd0, 3'd3}, 1'b1, '{1'b0, 3'd0, 1'b0, 16'd0, 7'd1}},
        '{'{ACT_CONVERT_END, 2'd3, 1'b1, 10'd1023, 3'd7}, 1'b1, NO_RESULT},
        '{'{ACT_READ, 2'd3, 1'b1, 10'd1023, 3'd7}, 1'b1, NO_RESULT},
        '{'{ACT_COMPARE, 2'd1, 1'b1, 10'd512, 3'd5}, 1'b0, NO_RESULT},
        '{'{ACT_CONVERT_END, 2'd2, 1'b1, 10'd682, 3'd2}, 1'b0, NO_RESULT},
        '{'{ACT_READ, 2'd1, 1'b0, 10'd341, 3'd0}, 1'b0, NO_RESULT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_valid;
    t_out        o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [1:0]  active_cfg;
    logic [2:0]  led_chan_cfg [LED_SLOTS][2];
    logic        led_toggle [LED_SLOTS];
    logic [15:0] ch_sum [NUM_CH];
    logic [6:0]  ch_count [NUM_CH];
    logic        conv_pending;
    logic [2:0]  conv_channel;

    t_out pending_results [$];
    int   mismatch_count = 0;
    int   burst_left = 0;

    pwm_gated_adc_accumulator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_out predict_event(input t_in it);
        t_out        r;
        logic [2:0]  ch;
        logic        sel;
        logic [16:0] total;
        int          li;
        r = '0;
        case (it.action)
            ACT_COMPARE: begin
                if (it.led != 0 && it.led <= NUM_LEDS && it.led <= LED_SLOTS &&
                        it.led == active_cfg && it.pwm_low) begin
                    li = int'(it.led) - 1;
                    sel = led_toggle[li];
                    ch = led_chan_cfg[li][sel];
                    led_toggle[li] = ~sel;
                    r.convert_channel = ch;
                    if (ch < NUM_CH && ch_count[ch] < MAX_SAMPLES) begin
                        r.start_conversion = 1'b1;
                        conv_pending = 1'b1;
                        conv_channel = ch;
                    end
                end
            end
            ACT_CONVERT_END: begin
                if (conv_pending && it.pwm_low) begin
                    total = {1'b0, ch_sum[conv_channel]} + {7'd0, it.sample};
                    ch_sum[conv_channel] = total[16] ? 16'hFFFF : total[15:0];
                    if (ch_count[conv_channel] < 7'd127) begin
                        ch_count[conv_channel] = ch_count[conv_channel] + 7'd1;
                    end
                    r.sample_accepted = 1'b1;
                end
                conv_pending = 1'b0;
            end
            ACT_READ: begin
                if (it.read_channel < NUM_CH) begin
                    r.sum = ch_sum[it.read_channel];
                    r.count = ch_count[it.read_channel];
                    ch_sum[it.read_channel] = '0;
                    ch_count[it.read_channel] = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
        mismatch_count++;
        $display("%0t %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    task automatic send_item(input t_in it, input logic typed, input t_out typed_result);
        t_out predicted;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = predict_event(it);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic pace(input bit allow_gaps);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = allow_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                i_item <= IN_W'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic issue(input t_in it, input bit allow_gaps);
        send_item(it, 1'b0, NO_RESULT);
        pace(allow_gaps);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic [2:0] idx, input bit is_write,
                                input logic [31:0] data, output logic [31:0] rdata);
        int k;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            if (idx == REG_ACTIVE_LED) begin
                active_cfg = data[1:0];
            end else begin
                k = int'(idx) - int'(REG_LED1_VOLT);
                led_chan_cfg[k >> 1][k & 1] = data[2:0];
            end
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int n_items, input bit allow_gaps);
        int  sent;
        int  pick;
        int  r;
        t_in it;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            it = IN_W'($urandom);
            if (pick < 65) begin
                it.action = ACT_COMPARE;
                it.led = (active_cfg != 0) ? active_cfg : 2'($urandom_range(1, 3));
                it.pwm_low = ($urandom_range(0, 9) != 0);
                issue(it, allow_gaps);
                it = IN_W'($urandom);
                it.action = ACT_CONVERT_END;
                it.pwm_low = ($urandom_range(0, 9) != 0);
                r = $urandom_range(0, 9);
                it.sample = (r == 0) ? 10'd0 : (r == 1) ? 10'h3FF : 10'($urandom);
                issue(it, allow_gaps);
                sent += 2;
            end else begin
                if (pick < 72) begin
                    it.action = ACT_READ;
                end
                issue(it, allow_gaps);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t result: expected none, got %p", $time, o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.start_conversion !== want.start_conversion) begin
                    flag("start_conversion", 32'(want.start_conversion),
                         32'(o_result.start_conversion));
                end
                if (o_result.convert_channel !== want.convert_channel) begin
                    flag("convert_channel", 32'(want.convert_channel),
                         32'(o_result.convert_channel));
                end
                if (o_result.sample_accepted !== want.sample_accepted) begin
                    flag("sample_accepted", 32'(want.sample_accepted),
                         32'(o_result.sample_accepted));
                end
                if (o_result.sum !== want.sum) begin
                    flag("sum", 32'(want.sum), 32'(o_result.sum));
                end
                if (o_result.count !== want.count) begin
                    flag("count", 32'(want.count), 32'(o_result.count));
                end
            end
        end
    end

    initial begin
        logic [2:0]  value [7];
        logic [31:0] mask;
        logic [31:0] rd;
        int          phase;
        int          r;
        active_cfg = 2'd1;
        led_chan_cfg[0][0] = 3'd0;
        led_chan_cfg[0][1] = 3'd3;
        led_chan_cfg[1][0] = 3'd1;
        led_chan_cfg[1][1] = 3'd6;
        led_chan_cfg[2][0] = 3'd2;
        led_chan_cfg[2][1] = 3'd7;
        foreach (led_toggle[i]) led_toggle[i] = 1'b0;
        foreach (ch_sum[i]) begin
            ch_sum[i] = '0;
            ch_count[i] = '0;
        end
        conv_pending = 1'b0;
        conv_channel = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++) begin
            send_item(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);
            pace(1'b1);
        end
        settle();

        for (phase = 0; phase < 6; phase++) begin
            for (r = REG_ACTIVE_LED; r <= REG_LED3_CURR; r++) begin
                value[r] = 3'($urandom_range(0, 7));
            end
            value[REG_ACTIVE_LED] = (phase < 4) ? 3'(phase) : 3'($urandom_range(0, 3));
            if (phase == 1) begin
                value[REG_LED1_VOLT] = 3'd7;
                value[REG_LED1_CURR] = 3'd7;
            end
            if (phase == 2) begin
                value[REG_LED2_VOLT] = 3'd0;
                value[REG_LED2_CURR] = 3'd0;
            end
            for (r = REG_ACTIVE_LED; r <= REG_LED3_CURR; r++) begin
                mask = (r == REG_ACTIVE_LED) ? 32'h3 : 32'h7;
                apb_transfer(3'(r), 1'b1, ($urandom & ~mask) | {29'd0, value[r]}, rd);
                apb_transfer(3'(r), 1'b0, $urandom, rd);
                if (rd !== ({29'd0, value[r]} & mask)) begin
                    flag("register readback", {29'd0, value[r]} & mask, rd);
                end
            end
            run_random((phase == 1) ? 220 : 50, phase != 3);
            settle();
        end

        if (mismatch_count == 0) begin
            $display("pwm_gated_adc_accumulator_tb: done, clean");
        end else begin
            $display("pwm_gated_adc_accumulator_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("pwm_gated_adc_accumulator_tb: done, errors");
        $finish;
    end

endmodule

FILE: pwm_gated_adc_accumulator.f
rtl/pga_pkg.sv
rtl/pga_regs.sv
rtl/pga_core.sv
rtl/pwm_gated_adc_accumulator.sv
rtl/pga_checker.sv
tb/pwm_gated_adc_accumulator_tb.sv
